// ===== rtl/ioh_pkg.sv =====
package ioh_pkg;

    // Defaults for the top-level parameters
    localparam int RULES_DEF      = 4;
    localparam int COUNT_BITS_DEF = 32;

    // Register port
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_BITS     = 38;
    localparam int RULE_COUNT_W = 3;

    // Histogram storage: one memory per direction and octet position,
    // two banks of 256 bins in each, every entry tagged with its interval number
    localparam int LANES      = 8;
    localparam int ADDR_BITS  = 9;
    localparam int MEM_DEPTH  = 1 << ADDR_BITS;
    localparam int EPOCH_BITS = 32;
    localparam logic [EPOCH_BITS-1:0] EPOCH_INIT = EPOCH_BITS'(1);

    // Queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_PACKET = 2'd0,
        CMD_READ   = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_INTERVAL   = 3'd0,
        REG_RULE_COUNT = 3'd1,
        REG_RULE_A     = 3'd2,
        REG_RULE_B     = 3'd3,
        REG_RULE_C     = 3'd4,
        REG_RULE_D     = 3'd5
    } reg_idx_t;

    // Classified item handed from front to back
    typedef struct packed {
        cmd_t                  cmd;
        logic [31:0]           ts;
        logic [31:0]           src_addr;
        logic [31:0]           dst_addr;
        logic                  count_src;
        logic                  count_dst;
        logic                  close;
        logic [EPOCH_BITS-1:0] epoch;
        logic                  read_dir;
        logic [1:0]            read_octet;
        logic [7:0]            read_value;
    } item_t;

    // Network mask for a prefix length; lengths above 32 count as 32
    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        logic [5:0]  len;
        logic [31:0] m;
        len = (plen > 6'd32) ? 6'd32 : plen;
        m   = (len == 6'd0) ? 32'd0 : (32'hffff_ffff << (6'd32 - len));
        return m;
    endfunction

    // Octet of an address, position 0 is the top byte
    function automatic logic [7:0] octet_of(input logic [31:0] addr, input logic [1:0] pos);
        logic [7:0] v;
        case (pos)
            2'd0:    v = addr[31:24];
            2'd1:    v = addr[23:16];
            2'd2:    v = addr[15:8];
            default: v = addr[7:0];
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ioh_front.sv =====
module ioh_front #(
    parameter int RULES = ioh_pkg::RULES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [ioh_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ioh_pkg::CFG_BITS-1:0]      cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ioh_pkg::cmd_t                     in_cmd,
    input  logic [31:0]                       in_ts,
    input  logic                              in_src_valid,
    input  logic [31:0]                       in_src_addr,
    input  logic                              in_dst_valid,
    input  logic [31:0]                       in_dst_addr,
    input  logic                              in_read_dir,
    input  logic [1:0]                        in_read_octet,
    input  logic [7:0]                        in_read_value,
    input  logic                              q_ready,
    input  logic                              clear_done,
    output logic                              push,
    output ioh_pkg::item_t                    push_item
);

    logic [31:0]                          interval_reg;
    logic [ioh_pkg::RULE_COUNT_W-1:0]     rule_count_reg;
    logic [ioh_pkg::CFG_BITS-1:0]         rule_reg [RULES];
    logic                                 started_reg, started_next;
    logic [31:0]                          key_reg, key_next;
    logic [ioh_pkg::EPOCH_BITS-1:0]       epoch_reg, epoch_next;

    logic [31:0] key_eff;
    logic [32:0] limit;
    logic        pkt_close;
    logic        close;
    logic        src_excl, dst_excl;
    logic        accept;

    assign in_ready = q_ready && clear_done;
    assign accept   = in_valid && in_ready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg   <= 32'd300;
            rule_count_reg <= '0;
            for (int r = 0; r < RULES; r++) begin
                rule_reg[r] <= '0;
            end
        end else if (cfg_we) begin
            unique case (ioh_pkg::reg_idx_t'(cfg_index))
                ioh_pkg::REG_INTERVAL:   interval_reg   <= cfg_wdata[31:0];
                ioh_pkg::REG_RULE_COUNT: rule_count_reg <= cfg_wdata[ioh_pkg::RULE_COUNT_W-1:0];
                default: begin
                    for (int r = 0; r < RULES; r++) begin
                        if (cfg_index == ioh_pkg::CFG_IDX_BITS'(int'(ioh_pkg::REG_RULE_A) + r)) begin
                            rule_reg[r] <= cfg_wdata;
                        end
                    end
                end
            endcase
        end
    end

    // Match both addresses against the active exclusion rules
    always_comb begin
        logic [31:0] m;
        logic [31:0] net;
        src_excl = 1'b0;
        dst_excl = 1'b0;
        for (int r = 0; r < RULES; r++) begin
            m   = ioh_pkg::prefix_mask(rule_reg[r][5:0]);
            net = rule_reg[r][37:6];
            if (ioh_pkg::RULE_COUNT_W'(r) < rule_count_reg) begin
                if ((in_src_addr & m) == (net & m)) src_excl = 1'b1;
                if ((in_dst_addr & m) == (net & m)) dst_excl = 1'b1;
            end
        end
    end

    // Interval close decision
    assign key_eff   = started_reg ? key_reg : in_ts;
    assign limit     = {1'b0, key_eff} + {1'b0, interval_reg};
    assign pkt_close = ({1'b0, in_ts} >= limit);

    always_comb begin
        close = 1'b0;
        case (in_cmd)
            ioh_pkg::CMD_PACKET: close = pkt_close;
            ioh_pkg::CMD_FLUSH:  close = 1'b1;
            default:             close = 1'b0;
        endcase
    end

    // Next interval state
    always_comb begin
        started_next = started_reg;
        key_next     = key_reg;
        epoch_next   = epoch_reg;
        if (accept) begin
            if (in_cmd == ioh_pkg::CMD_PACKET) begin
                started_next = 1'b1;
                key_next     = pkt_close ? in_ts : key_eff;
            end
            if (close) begin
                epoch_next = epoch_reg + ioh_pkg::EPOCH_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            key_reg     <= '0;
            epoch_reg   <= ioh_pkg::EPOCH_INIT;
        end else begin
            started_reg <= started_next;
            key_reg     <= key_next;
            epoch_reg   <= epoch_next;
        end
    end

    // Build the queue entry
    assign push = accept;
    always_comb begin
        push_item            = '0;
        push_item.cmd        = in_cmd;
        push_item.ts         = in_ts;
        push_item.src_addr   = in_src_addr;
        push_item.dst_addr   = in_dst_addr;
        push_item.count_src  = (in_cmd == ioh_pkg::CMD_PACKET) && in_src_valid && !src_excl;
        push_item.count_dst  = (in_cmd == ioh_pkg::CMD_PACKET) && in_dst_valid && !dst_excl;
        push_item.close      = close;
        push_item.epoch      = epoch_reg;
        push_item.read_dir   = in_read_dir;
        push_item.read_octet = in_read_octet;
        push_item.read_value = in_read_value;
    end

endmodule

// ===== rtl/ioh_queue.sv =====
module ioh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ioh_pkg::item_t push_item,
    output logic           q_ready,
    output logic           q_valid,
    output ioh_pkg::item_t q_item,
    input  logic           pop
);

    localparam int PTR_BITS = $clog2(ioh_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(ioh_pkg::QUEUE_DEPTH + 1);

    ioh_pkg::item_t      slot_reg [ioh_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    assign q_ready = (cnt_reg != CNT_BITS'(ioh_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) wr_ptr_next = wr_ptr_reg + PTR_BITS'(1);
        if (pop)  rd_ptr_next = rd_ptr_reg + PTR_BITS'(1);
        if (push && !pop) cnt_next = cnt_reg + CNT_BITS'(1);
        if (pop && !push) cnt_next = cnt_reg - CNT_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/ioh_back.sv =====
module ioh_back #(
    parameter int COUNT_BITS = ioh_pkg::COUNT_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  ioh_pkg::item_t q_item,
    output logic           pop,
    output logic           clear_done,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_closed,
    output logic [31:0]    out_packets,
    output logic [31:0]    out_seconds,
    output logic [31:0]    out_bin
);

    localparam int EB    = ioh_pkg::EPOCH_BITS;
    localparam int AB    = ioh_pkg::ADDR_BITS;
    localparam int ENTRY = EB + COUNT_BITS;
    localparam int LN    = ioh_pkg::LANES;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [31:0] to32(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+31:0] w;
        w = {32'd0, v};
        return w[31:0];
    endfunction

    // Clearing sweep after reset
    logic [AB:0] clr_reg;
    assign clear_done = clr_reg[AB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (!clear_done) begin
            clr_reg <= clr_reg + (AB+1)'(1);
        end
    end

    // Pipeline control: head of queue reads, W stage writes and produces the item
    logic           adv;
    logic           w_valid_reg;
    ioh_pkg::item_t w_item_reg;
    logic           out_valid_reg;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && q_valid && clear_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (adv) begin
            w_valid_reg <= pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) w_item_reg <= q_item;
    end

    // Per-lane histogram memories
    logic [AB-1:0]         raddr     [LN];
    logic [AB-1:0]         w_addr_reg[LN];
    logic [ENTRY-1:0]      rd_reg    [LN];
    logic                  byp_hit_reg [LN];
    logic [ENTRY-1:0]      byp_data_reg[LN];
    logic                  we_item   [LN];
    logic [ENTRY-1:0]      wdata     [LN];
    logic [COUNT_BITS-1:0] snap_cnt  [LN];

    for (genvar l = 0; l < LN; l++) begin : g_lane
        logic [ENTRY-1:0]      bins_reg [ioh_pkg::MEM_DEPTH];
        logic [ENTRY-1:0]      stored;
        logic [EB-1:0]         tag;
        logic [COUNT_BITS-1:0] cnt;
        logic [COUNT_BITS-1:0] live_cnt;
        logic                  lane_dir;
        logic [1:0]            lane_pos;
        logic [31:0]           head_addr;
        logic                  mem_we;
        logic [AB-1:0]         mem_waddr;
        logic [ENTRY-1:0]      mem_wdata;

        assign lane_dir = 1'((l >> 2) & 1);
        assign lane_pos = 2'(l & 3);

        // Read address for the item at the head of the queue
        assign head_addr = lane_dir ? q_item.dst_addr : q_item.src_addr;
        always_comb begin
            if (q_item.cmd == ioh_pkg::CMD_READ) begin
                raddr[l] = {~q_item.epoch[0], q_item.read_value};
            end else begin
                raddr[l] = {q_item.epoch[0], ioh_pkg::octet_of(head_addr, lane_pos)};
            end
        end

        // Resolve the entry seen by the W stage
        assign stored   = byp_hit_reg[l] ? byp_data_reg[l] : rd_reg[l];
        assign tag      = stored[ENTRY-1:COUNT_BITS];
        assign cnt      = stored[COUNT_BITS-1:0];
        assign live_cnt = (tag == w_item_reg.epoch) ? cnt : '0;
        assign snap_cnt[l] = (tag == (w_item_reg.epoch - EB'(1))) ? cnt : '0;

        assign we_item[l] = adv && w_valid_reg && (w_item_reg.cmd == ioh_pkg::CMD_PACKET)
                            && (lane_dir ? w_item_reg.count_dst : w_item_reg.count_src);
        assign wdata[l]   = {w_item_reg.epoch, sat_inc(live_cnt)};

        assign mem_we    = !clear_done || we_item[l];
        assign mem_waddr = clear_done ? w_addr_reg[l] : clr_reg[AB-1:0];
        assign mem_wdata = clear_done ? wdata[l] : '0;

        always_ff @(posedge aclk) begin
            if (mem_we) bins_reg[mem_waddr] <= mem_wdata;
            if (adv) begin
                rd_reg[l]       <= bins_reg[raddr[l]];
                w_addr_reg[l]   <= raddr[l];
                byp_hit_reg[l]  <= we_item[l] && (w_addr_reg[l] == raddr[l]);
                byp_data_reg[l] <= wdata[l];
            end
        end
    end

    // Packet counter and result
    logic [COUNT_BITS-1:0] live_pk_reg, live_pk_next;
    logic [COUNT_BITS-1:0] pk_inc;
    logic [COUNT_BITS-1:0] res_pk;
    logic [COUNT_BITS-1:0] res_bin;
    logic                  w_fire;

    assign w_fire = adv && w_valid_reg;
    assign pk_inc = sat_inc(live_pk_reg);

    always_comb begin
        live_pk_next = live_pk_reg;
        res_pk       = '0;
        res_bin      = '0;
        case (w_item_reg.cmd)
            ioh_pkg::CMD_PACKET: begin
                if (w_item_reg.close) begin
                    res_pk       = pk_inc;
                    live_pk_next = '0;
                end else begin
                    live_pk_next = pk_inc;
                end
            end
            ioh_pkg::CMD_FLUSH: begin
                res_pk       = live_pk_reg;
                live_pk_next = '0;
            end
            ioh_pkg::CMD_READ: begin
                res_bin = snap_cnt[{w_item_reg.read_dir, w_item_reg.read_octet}];
            end
            default: begin
                live_pk_next = live_pk_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_pk_reg <= '0;
        end else if (w_fire) begin
            live_pk_reg <= live_pk_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= w_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (w_fire) begin
            out_closed  <= w_item_reg.close;
            out_packets <= to32(res_pk);
            out_seconds <= w_item_reg.close ? w_item_reg.ts : 32'd0;
            out_bin     <= to32(res_bin);
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/ipv4_octet_histogram_interval_unit.sv =====
// Channel   | Dir | Handshake        | Content
// ----------+-----+------------------+------------------------------------------
// s_        | in  | s_tvalid/tready  | one item: packet, snapshot read or flush
// m_        | out | m_tvalid/tready  | one result item per input item
// cfg_      | in  | cfg_we           | interval, rule count, exclusion rules
//
// One item per cycle sustained while m_tready stays high; m_tvalid for an item
// rises once it has passed the queue slot, the memory read into the W stage and
// the output register.
// Eight banked histogram memories (direction by octet position) give one
// read-modify-write per packet per memory in each cycle that the pipeline advances.
// After reset a sweep clears all 512 entries of each memory; s_tready stays low
// until it ends. A stall on m_ fills the four-entry queue before s_tready drops.
module ipv4_octet_histogram_interval_unit #(
    parameter int RULES      = ioh_pkg::RULES_DEF,
    parameter int COUNT_BITS = ioh_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ioh_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ioh_pkg::CFG_BITS-1:0]     cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // timestamp_seconds, src_valid, src_addr, dst_valid, dst_addr,
    // read_direction, read_octet, read_value, zero pad
    input  logic [111:0]                     s_tdata,
    // cmd
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // interval_closed, closed_packets, closed_seconds, bin_count, zero pad
    output logic [103:0]                     m_tdata
);

    logic           q_ready;
    logic           q_valid;
    logic           clear_done;
    logic           push;
    logic           pop;
    ioh_pkg::item_t push_item;
    ioh_pkg::item_t q_item;
    logic           out_closed;
    logic [31:0]    out_packets;
    logic [31:0]    out_seconds;
    logic [31:0]    out_bin;

    ioh_front #(
        .RULES(RULES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (ioh_pkg::cmd_t'(s_tuser)),
        .in_ts         (s_tdata[31:0]),
        .in_src_valid  (s_tdata[32]),
        .in_src_addr   (s_tdata[64:33]),
        .in_dst_valid  (s_tdata[65]),
        .in_dst_addr   (s_tdata[97:66]),
        .in_read_dir   (s_tdata[98]),
        .in_read_octet (s_tdata[100:99]),
        .in_read_value (s_tdata[108:101]),
        .q_ready       (q_ready),
        .clear_done    (clear_done),
        .push          (push),
        .push_item     (push_item)
    );

    ioh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    ioh_back #(
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop),
        .clear_done  (clear_done),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_closed  (out_closed),
        .out_packets (out_packets),
        .out_seconds (out_seconds),
        .out_bin     (out_bin)
    );

    assign m_tdata = {7'd0, out_bin, out_seconds, out_packets, out_closed};

endmodule
